/* src/cfsr_pkg.sv */
// cfsr_pkg: shared types, constants and the CRC-8 helper for the command
// framer and status reporter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfsr_pkg;

  localparam int BYTE_W       = 8;
  localparam int ELAPSED_W    = 16;
  localparam int POS_W        = 32;
  localparam int INTERVAL_W   = 20;
  localparam int COUNT_W      = 32;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_INDEX_W  = 1;

  localparam int STATUS_BYTES = 24;
  localparam int STAT_IDX_W   = 5;
  localparam int MAX_REPLAY   = 24;

  localparam logic [BYTE_W-1:0]     CRC_POLY          = 8'h07;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET    = 20'd10000;
  localparam logic [BYTE_W-1:0]     VERSION_RESET     = 8'd23;

  // item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // out_kind codes
  localparam logic OUT_COMMAND = 1'b0;
  localparam logic OUT_STATUS  = 1'b1;

  // status byte codes
  localparam logic [BYTE_W-1:0] STAT_IDLE      = 8'd0;
  localparam logic [BYTE_W-1:0] STAT_MOVING    = 8'd1;
  localparam logic [BYTE_W-1:0] STAT_CRC_ERROR = 8'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REPORT_INTERVAL  = 1'b0,
    REG_FIRMWARE_VERSION = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } out_item_t;

  // CRC-8, MSB first, no reflection, no final xor
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/cfsr_if.sv */
// cfsr_if: valid/ready stream interfaces for input items and result items.
// Depends on cfsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cfsr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic        [cfsr_pkg::BYTE_W-1:0]    rx_byte;
  logic        [cfsr_pkg::ELAPSED_W-1:0] elapsed_us;
  logic                                  motion_active;
  logic signed [cfsr_pkg::POS_W-1:0]     x_pos;
  logic signed [cfsr_pkg::POS_W-1:0]     y_pos;
  logic signed [cfsr_pkg::POS_W-1:0]     z_pos;
  logic signed [cfsr_pkg::POS_W-1:0]     w_pos;
  logic                                  joystick_pressed;

  modport source (output valid, kind, rx_byte, elapsed_us, motion_active,
                  x_pos, y_pos, z_pos, w_pos, joystick_pressed,
                  input ready);
  modport sink   (input valid, kind, rx_byte, elapsed_us, motion_active,
                  x_pos, y_pos, z_pos, w_pos, joystick_pressed,
                  output ready);
endinterface

interface cfsr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_kind;
  logic [cfsr_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_last;

  modport source (output valid, out_kind, out_byte, out_last, input ready);
  modport sink   (input valid, out_kind, out_byte, out_last, output ready);
endinterface

`default_nettype wire

/* src/crc8_command_framer_and_status_reporter.sv */
// Top level of the host-link command framer and status reporter.
// Depends on cfsr_pkg, cfsr_if, cfsr_frame_ram and cfsr_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Host bytes (kind 0) fill a FRAME_BYTES command frame held in a small
// synchronous RAM; the last byte is a CRC-8 (poly 0x07, init 0) over the rest,
// accumulated as the frame fills. A good frame is replayed from the RAM,
// without its CRC, as min(FRAME_BYTES-1, 24) command items; each replayed
// byte goes through a RAM read state, then an output load state, as the RAM
// read is registered. A bad frame is not replayed; it sets the error flag.
// A report tick (kind 1) adds elapsed_us to a saturating 32-bit counter; when
// it reaches report_interval_us, or motion_active just fell, a 24-byte status
// frame is sent at one byte per cycle, its CRC built serially as the bytes go
// out. Output backpressure stretches both runs. cmd_in.ready is high only
// between runs, so an item with results occupies the block for its whole run;
// the last result may still sit in the output register when the next item is
// taken. Configuration writes are taken at any time but belong between items.

module crc8_command_framer_and_status_reporter #(
  parameter int FRAME_BYTES = 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write,
  input  wire  [cfsr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [cfsr_pkg::CFG_DATA_W-1:0]       cfg_data,
  cfsr_in_if.sink                               cmd_in,
  cfsr_out_if.source                            rsp_out
);

  localparam int AW         = $clog2(FRAME_BYTES);
  localparam int REPLAY_CNT = (FRAME_BYTES - 1 > cfsr_pkg::MAX_REPLAY) ?
                              cfsr_pkg::MAX_REPLAY : FRAME_BYTES - 1;
  localparam logic [AW-1:0] LAST_WIDX  = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] LAST_REPLY = AW'(REPLAY_CNT - 1);
  localparam logic [cfsr_pkg::STAT_IDX_W-1:0] LAST_STAT =
    cfsr_pkg::STAT_IDX_W'(cfsr_pkg::STATUS_BYTES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RD     = 4'b0010,
    ST_REPLAY = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [cfsr_pkg::INTERVAL_W-1:0] report_interval_us;
  logic [cfsr_pkg::BYTE_W-1:0]     firmware_version;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval_us <= cfsr_pkg::INTERVAL_RESET;
      firmware_version   <= cfsr_pkg::VERSION_RESET;
    end else if (cfg_write) begin
      unique case (cfsr_pkg::cfg_reg_t'(cfg_index))
        cfsr_pkg::REG_REPORT_INTERVAL:  report_interval_us <= cfg_data;
        cfsr_pkg::REG_FIRMWARE_VERSION: firmware_version   <=
                                          cfg_data[cfsr_pkg::BYTE_W-1:0];
      endcase
    end
  end

  // framer state
  logic [AW-1:0]                write_index;
  logic [cfsr_pkg::BYTE_W-1:0]  running_crc;
  logic [cfsr_pkg::BYTE_W-1:0]  first_byte;
  logic [cfsr_pkg::BYTE_W-1:0]  last_command_id;
  logic                         crc_error_flag;
  logic                         was_moving;
  logic [cfsr_pkg::COUNT_W-1:0] since_report_us;

  // run state
  logic [AW-1:0]                    replay_idx;
  logic [cfsr_pkg::STAT_IDX_W-1:0]  stat_idx;
  logic [cfsr_pkg::BYTE_W-1:0]      stat_crc;
  logic [cfsr_pkg::BYTE_W-1:0]      stat_code;
  logic                             joy_q;
  logic [cfsr_pkg::POS_W-1:0]       x_q, y_q, z_q, w_q;

  logic accept;
  logic is_byte, is_tick;
  logic frame_done;
  logic crc_ok;
  logic can_push;
  logic push;
  cfsr_pkg::out_item_t push_item;

  assign cmd_in.ready = (state == ST_IDLE);
  assign accept       = cmd_in.valid && cmd_in.ready;
  assign is_byte      = accept && (cmd_in.kind == cfsr_pkg::KIND_BYTE);
  assign is_tick      = accept && (cmd_in.kind == cfsr_pkg::KIND_TICK);
  assign frame_done   = (write_index == LAST_WIDX);
  assign crc_ok       = (running_crc == cmd_in.rx_byte);

  // report counter: saturating add and compare
  logic [cfsr_pkg::COUNT_W:0]   sum_wide;
  logic [cfsr_pkg::COUNT_W-1:0] sum_sat;
  logic                         falling;
  logic                         fire;

  assign sum_wide = {1'b0, since_report_us} +
                    (cfsr_pkg::COUNT_W+1)'(cmd_in.elapsed_us);
  assign sum_sat  = sum_wide[cfsr_pkg::COUNT_W] ? '1 : sum_wide[cfsr_pkg::COUNT_W-1:0];
  assign falling  = was_moving && !cmd_in.motion_active;
  assign fire     = (sum_sat >= cfsr_pkg::COUNT_W'(report_interval_us)) || falling;

  // frame RAM
  logic                        ram_re;
  logic [cfsr_pkg::BYTE_W-1:0] ram_q;

  assign ram_re = (state == ST_RD);

  cfsr_frame_ram #(.DEPTH(FRAME_BYTES)) u_ram (
    .clk   (clk),
    .we    (is_byte),
    .waddr (write_index),
    .wdata (cmd_in.rx_byte),
    .re    (ram_re),
    .raddr (replay_idx),
    .rdata (ram_q)
  );

  // status frame byte select
  logic [cfsr_pkg::BYTE_W-1:0] stat_bytes [cfsr_pkg::STATUS_BYTES];
  logic [cfsr_pkg::BYTE_W-1:0] stat_byte;

  always_comb begin
    for (int i = 0; i < cfsr_pkg::STATUS_BYTES; i++) begin
      stat_bytes[i] = '0;
    end
    stat_bytes[0]  = last_command_id;
    stat_bytes[1]  = stat_code;
    for (int k = 0; k < 4; k++) begin
      stat_bytes[2 + k]  = x_q[31 - 8*k -: 8];
      stat_bytes[6 + k]  = y_q[31 - 8*k -: 8];
      stat_bytes[10 + k] = z_q[31 - 8*k -: 8];
      stat_bytes[14 + k] = w_q[31 - 8*k -: 8];
    end
    stat_bytes[18] = {7'd0, joy_q};
    stat_bytes[22] = firmware_version;
    stat_bytes[23] = stat_crc;
  end

  assign stat_byte = stat_bytes[stat_idx];

  // result selection
  always_comb begin
    push      = 1'b0;
    push_item = '{out_kind: cfsr_pkg::OUT_COMMAND, out_byte: ram_q,
                  out_last: (replay_idx == LAST_REPLY)};
    if (state == ST_REPLAY) begin
      push = 1'b1;
    end else if (state == ST_STATUS) begin
      push      = 1'b1;
      push_item = '{out_kind: cfsr_pkg::OUT_STATUS, out_byte: stat_byte,
                    out_last: (stat_idx == LAST_STAT)};
    end
  end

  cfsr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .can_push  (can_push),
    .rsp       (rsp_out)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_index     <= '0;
      running_crc     <= '0;
      last_command_id <= '0;
      crc_error_flag  <= 1'b0;
      was_moving      <= 1'b0;
      since_report_us <= '0;
      replay_idx      <= '0;
      stat_idx        <= '0;
      stat_crc        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (is_byte) begin
            if (!frame_done) begin
              running_crc <= cfsr_pkg::crc8_step(
                               (write_index == '0) ? '0 : running_crc, cmd_in.rx_byte);
              write_index <= write_index + 1'b1;
            end else begin
              write_index     <= '0;
              running_crc     <= '0;
              last_command_id <= first_byte;
              crc_error_flag  <= !crc_ok;
              replay_idx      <= '0;
              if (crc_ok) begin
                state <= ST_RD;
              end
            end
          end else if (is_tick) begin
            was_moving      <= cmd_in.motion_active;
            since_report_us <= fire ? '0 : sum_sat;
            stat_idx        <= '0;
            stat_crc        <= '0;
            if (fire) begin
              state <= ST_STATUS;
            end
          end
        end
        ST_RD: begin
          state <= ST_REPLAY;
        end
        ST_REPLAY: begin
          if (can_push) begin
            replay_idx <= replay_idx + 1'b1;
            state      <= (replay_idx == LAST_REPLY) ? ST_IDLE : ST_RD;
          end
        end
        ST_STATUS: begin
          if (can_push) begin
            stat_crc <= cfsr_pkg::crc8_step(stat_crc, stat_byte);
            stat_idx <= stat_idx + 1'b1;
            if (stat_idx == LAST_STAT) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload captures
  always_ff @(posedge clk) begin
    if (is_byte && write_index == '0) begin
      first_byte <= cmd_in.rx_byte;
    end
    if (is_tick) begin
      x_q   <= cmd_in.x_pos;
      y_q   <= cmd_in.y_pos;
      z_q   <= cmd_in.z_pos;
      w_q   <= cmd_in.w_pos;
      joy_q <= cmd_in.joystick_pressed;
      stat_code <= crc_error_flag       ? cfsr_pkg::STAT_CRC_ERROR :
                   cmd_in.motion_active ? cfsr_pkg::STAT_MOVING : cfsr_pkg::STAT_IDLE;
    end
  end

endmodule

`default_nettype wire

/* src/cfsr_frame_ram.sv */
// cfsr_frame_ram: command frame store, one write port and one registered
// read port. Depends on cfsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfsr_frame_ram #(
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [AW-1:0]                waddr,
  input  wire  [cfsr_pkg::BYTE_W-1:0] wdata,
  input  wire                          re,
  input  wire  [AW-1:0]                raddr,
  output logic [cfsr_pkg::BYTE_W-1:0] rdata
);

  logic [cfsr_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/cfsr_out_stage.sv */
// cfsr_out_stage: one-entry output register between the framer and the
// result channel. Depends on cfsr_pkg and cfsr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module cfsr_out_stage (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  cfsr_pkg::out_item_t  push_item,
  output logic                 can_push,
  cfsr_out_if.source           rsp
);

  logic                valid;
  cfsr_pkg::out_item_t item;

  assign can_push = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_push) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push && push) begin
      item <= push_item;
    end
  end

  assign rsp.valid    = valid;
  assign rsp.out_kind = item.out_kind;
  assign rsp.out_byte = item.out_byte;
  assign rsp.out_last = item.out_last;

endmodule

`default_nettype wire

/* tb/sv/crc8_command_framer_and_status_reporter_tb.sv */
// Self-checking bench for the CRC-8 command framer and status reporter.
// Needs cfsr_pkg, cfsr_if and the framer RTL; a built-in predictor checks every result item.
`timescale 1ns / 1ps

module crc8_command_framer_and_status_reporter_tb;

  localparam int FRAME_BYTES   = 8;
  localparam int FB_AW         = $clog2(FRAME_BYTES);
  localparam int REPLAY_BYTES  = (FRAME_BYTES - 1 > cfsr_pkg::MAX_REPLAY) ?
                                 cfsr_pkg::MAX_REPLAY : FRAME_BYTES - 1;
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 10;      // quiet time before a register write
  localparam int TAIL_CYCLES   = 40;      // watch for stray items at the end
  localparam int LIMIT_CYCLES  = 200000;

  // command bodies for the directed frames (CRC byte is added on the fly)
  localparam logic [55:0] GOOD_BODY = 56'hFF_00_80_01_7F_AA_55;
  localparam logic [55:0] BAD_BODY  = 56'h5A_FF_00_11_22_33_44;

  typedef struct packed {
    logic                           kind;
    logic [cfsr_pkg::BYTE_W-1:0]    rx_byte;
    logic [cfsr_pkg::ELAPSED_W-1:0] elapsed_us;
    logic                           motion_active;
    logic [cfsr_pkg::POS_W-1:0]     x_pos;
    logic [cfsr_pkg::POS_W-1:0]     y_pos;
    logic [cfsr_pkg::POS_W-1:0]     z_pos;
    logic [cfsr_pkg::POS_W-1:0]     w_pos;
    logic                           joystick_pressed;
  } link_item_t;

  // how a directed byte row closes a frame
  typedef enum logic [1:0] {
    CLOSE_NONE,
    CLOSE_GOOD,
    CLOSE_BAD
  } close_t;

  typedef struct {
    link_item_t                  it;
    close_t                      close;
    int                          n_exp;     // -1: count not typed in
    int                          chk_at;    // result index of the typed byte
    logic [cfsr_pkg::BYTE_W-1:0] chk_byte;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write;
  logic [cfsr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cfsr_pkg::CFG_DATA_W-1:0]  cfg_data;

  cfsr_in_if  cmd_in ();
  cfsr_out_if rsp_out ();

  crc8_command_framer_and_status_reporter #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_in   (cmd_in),
    .rsp_out  (rsp_out)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor state: frame assembly, status counter, register copies
  // ---------------------------------------------------------------------
  logic [cfsr_pkg::BYTE_W-1:0]     fb_bytes [FRAME_BYTES];
  int unsigned                     fb_idx;
  logic [cfsr_pkg::BYTE_W-1:0]     fb_crc;
  logic [cfsr_pkg::BYTE_W-1:0]     fb_last_id;
  logic                            fb_crc_bad;
  logic                            mv_prev;
  logic [cfsr_pkg::COUNT_W-1:0]    since_us;
  logic [cfsr_pkg::INTERVAL_W-1:0] p_interval;
  logic [cfsr_pkg::BYTE_W-1:0]     p_version;

  cfsr_pkg::out_item_t pending_bytes [$];   // result items still owed by the block

  int errors    = 0;
  int items_sent = 0;
  int idle_pct  = 32;   // idle chance per cycle, both sides
  int hold_reqs = 0;    // bumped to ask the receiver for a long hold-off
  int cycles    = 0;

  // MSB-first CRC-8, poly 0x07, no reflection
  function automatic logic [cfsr_pkg::BYTE_W-1:0] crc8_fold(
      input logic [cfsr_pkg::BYTE_W-1:0] crc,
      input logic [cfsr_pkg::BYTE_W-1:0] b);
    logic [cfsr_pkg::BYTE_W-1:0] r;
    r = crc ^ b;
    repeat (cfsr_pkg::BYTE_W)
      r = {r[cfsr_pkg::BYTE_W-2:0], 1'b0} ^ (r[cfsr_pkg::BYTE_W-1] ? cfsr_pkg::CRC_POLY : 8'h00);
    return r;
  endfunction

  // advance the predictor by one accepted item, queue what it must emit
  function automatic int forecast_bytes(input link_item_t it);
    logic [cfsr_pkg::BYTE_W-1:0] st [cfsr_pkg::STATUS_BYTES];
    logic [cfsr_pkg::POS_W-1:0]  pos [4];
    logic [cfsr_pkg::BYTE_W-1:0] c;
    logic                        falling;
    int                          n;
    n = 0;
    if (it.kind == cfsr_pkg::KIND_BYTE) begin
      fb_bytes[FB_AW'(fb_idx)] = it.rx_byte;
      if (fb_idx + 1 < FRAME_BYTES) begin
        fb_crc = crc8_fold((fb_idx == 0) ? 8'h00 : fb_crc, it.rx_byte);
        fb_idx++;
      end else begin
        // id is latched on every complete frame, good or bad
        fb_idx     = 0;
        fb_last_id = fb_bytes[0];
        fb_crc_bad = (fb_crc != it.rx_byte);
        if (!fb_crc_bad) begin
          for (int i = 0; i < REPLAY_BYTES; i++) begin
            pending_bytes.push_back(cfsr_pkg::out_item_t'{cfsr_pkg::OUT_COMMAND, fb_bytes[i],
                                                          (i == REPLAY_BYTES - 1)});
            n++;
          end
        end
        fb_crc = '0;
      end
      return n;
    end

    // report tick
    falling = mv_prev && !it.motion_active;
    mv_prev = it.motion_active;
    if (since_us > 32'hFFFF_FFFF - (cfsr_pkg::COUNT_W)'(it.elapsed_us))
      since_us = '1;
    else
      since_us = since_us + (cfsr_pkg::COUNT_W)'(it.elapsed_us);
    if (since_us < (cfsr_pkg::COUNT_W)'(p_interval) && !falling)
      return 0;
    since_us = '0;

    foreach (st[i]) st[i] = '0;
    st[0] = fb_last_id;
    st[1] = fb_crc_bad ? cfsr_pkg::STAT_CRC_ERROR :
            (it.motion_active ? cfsr_pkg::STAT_MOVING : cfsr_pkg::STAT_IDLE);
    pos[0] = it.x_pos;
    pos[1] = it.y_pos;
    pos[2] = it.z_pos;
    pos[3] = it.w_pos;
    for (int a = 0; a < 4; a++)
      for (int k = 0; k < 4; k++)
        st[2 + 4 * a + k] = pos[a][cfsr_pkg::POS_W - 1 - 8 * k -: 8];
    st[18] = {7'b0, it.joystick_pressed};
    st[22] = p_version;
    c = '0;
    for (int i = 0; i < cfsr_pkg::STATUS_BYTES - 1; i++) c = crc8_fold(c, st[i]);
    st[cfsr_pkg::STATUS_BYTES - 1] = c;
    for (int i = 0; i < cfsr_pkg::STATUS_BYTES; i++)
      pending_bytes.push_back(cfsr_pkg::out_item_t'{cfsr_pkg::OUT_STATUS, st[i],
                                                    (i == cfsr_pkg::STATUS_BYTES - 1)});
    return cfsr_pkg::STATUS_BYTES;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // random item; byte items carry random junk in the tick fields
  function automatic link_item_t rand_link(input logic k, input int el_small);
    link_item_t it;
    it.kind             = k;
    it.rx_byte          = (cfsr_pkg::BYTE_W)'($urandom_range(0, 255));
    it.elapsed_us       = (cfsr_pkg::ELAPSED_W)'(($urandom_range(0, 3) == 0) ?
                                                 $urandom_range(0, 65535) :
                                                 $urandom_range(0, el_small));
    it.motion_active    = ($urandom_range(0, 99) < 55);
    it.x_pos            = $urandom;
    it.y_pos            = $urandom;
    it.z_pos            = $urandom;
    it.w_pos            = $urandom;
    it.joystick_pressed = ($urandom_range(0, 1) == 1);
    return it;
  endfunction

  function automatic dir_row_t mk_tick(input logic [cfsr_pkg::ELAPSED_W-1:0] el,
                                       input logic mv,
                                       input logic [cfsr_pkg::POS_W-1:0] x,
                                       input logic [cfsr_pkg::POS_W-1:0] y,
                                       input logic [cfsr_pkg::POS_W-1:0] z,
                                       input logic [cfsr_pkg::POS_W-1:0] w,
                                       input logic joy, input int n_exp, input int at,
                                       input logic [cfsr_pkg::BYTE_W-1:0] val);
    dir_row_t r;
    r.it    = '{cfsr_pkg::KIND_TICK, 8'h00, el, mv, x, y, z, w, joy};
    r.close = CLOSE_NONE;
    r.n_exp = n_exp;
    r.chk_at = at;
    r.chk_byte = val;
    return r;
  endfunction

  function automatic dir_row_t mk_byte(input logic [cfsr_pkg::BYTE_W-1:0] b,
                                       input close_t cl,
                                       input int n_exp, input int at,
                                       input logic [cfsr_pkg::BYTE_W-1:0] val);
    dir_row_t r;
    r.it    = '{cfsr_pkg::KIND_BYTE, b, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0};
    r.close = cl;
    r.n_exp = n_exp;
    r.chk_at = at;
    r.chk_byte = val;
    return r;
  endfunction

  // offer one item with random idle cycles ahead of it; valid stays high on
  // return so a back-to-back item needs no extra edge
  task automatic send_item(input link_item_t it, output int n);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_in.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_in.valid            <= 1'b1;
    cmd_in.kind             <= it.kind;
    cmd_in.rx_byte          <= it.rx_byte;
    cmd_in.elapsed_us       <= it.elapsed_us;
    cmd_in.motion_active    <= it.motion_active;
    cmd_in.x_pos            <= it.x_pos;
    cmd_in.y_pos            <= it.y_pos;
    cmd_in.z_pos            <= it.z_pos;
    cmd_in.w_pos            <= it.w_pos;
    cmd_in.joystick_pressed <= it.joystick_pressed;
    @(posedge clk);
    while (!cmd_in.ready) @(posedge clk);
    n = forecast_bytes(it);
    items_sent++;
  endtask

  // bytes until the frame in progress closes; a good frame gets the right CRC.
  // Ticks drop in between bytes now and then.
  task automatic send_frame(input bit good, input int el_small);
    link_item_t it;
    int         n;
    do begin
      if ($urandom_range(0, 9) == 0) send_item(rand_link(cfsr_pkg::KIND_TICK, el_small), n);
      it = rand_link(cfsr_pkg::KIND_BYTE, el_small);
      if (good && fb_idx == FRAME_BYTES - 1) it.rx_byte = fb_crc;
      send_item(it, n);
    end while (fb_idx != 0);
  endtask

  task automatic run_phase(input int n_items, input int el_small);
    int stop;
    int n;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: send_frame(1'b1, el_small);
        8, 9, 10: send_frame(1'b0, el_small);
        // stray bytes: shift the frame boundary
        11: begin
          repeat ($urandom_range(1, 3)) send_item(rand_link(cfsr_pkg::KIND_BYTE, el_small), n);
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_item(rand_link(cfsr_pkg::KIND_TICK, el_small), n);
        end
      endcase
    end
  endtask

  // stop offering and wait until every owed item has come out
  task automatic drain_results(input int tail);
    cmd_in.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_regs(input logic [cfsr_pkg::INTERVAL_W-1:0] interval,
                          input logic [cfsr_pkg::BYTE_W-1:0] version);
    drain_results(SETTLE_CYCLES);
    cfg_write <= 1'b1;
    cfg_index <= cfsr_pkg::REG_REPORT_INTERVAL;
    cfg_data  <= (cfsr_pkg::CFG_DATA_W)'(interval);
    @(posedge clk);
    cfg_index <= cfsr_pkg::REG_FIRMWARE_VERSION;
    cfg_data  <= (cfsr_pkg::CFG_DATA_W)'(version);
    @(posedge clk);
    cfg_write  <= 1'b0;
    p_interval = interval;
    p_version  = version;
  endtask

  // ---------------------------------------------------------------------
  // result side: random ready, long hold-off on request, in-order checking
  // ---------------------------------------------------------------------
  initial begin
    cfsr_pkg::out_item_t got;
    cfsr_pkg::out_item_t want;
    int                  hold_seen;
    int                  hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_out.valid && rsp_out.ready) begin
        got = cfsr_pkg::out_item_t'{rsp_out.out_kind, rsp_out.out_byte, rsp_out.out_last};
        if (pending_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: expected none, actual kind %0h byte %0h last %0h",
                   $time, got.out_kind, got.out_byte, got.out_last);
        end else begin
          want = pending_bytes.pop_front();
          check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
          check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
          check_field("out_last", 32'(want.out_last), 32'(got.out_last));
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_out.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_out.ready <= 1'b0;
      end else begin
        rsp_out.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d items still owed", $time, pending_bytes.size());
      $display("crc8_command_framer_and_status_reporter_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t tab [$];
    dir_row_t r;
    int       n;

    cmd_in.valid            <= 1'b0;
    cmd_in.kind             <= cfsr_pkg::KIND_BYTE;
    cmd_in.rx_byte          <= '0;
    cmd_in.elapsed_us       <= '0;
    cmd_in.motion_active    <= 1'b0;
    cmd_in.x_pos            <= '0;
    cmd_in.y_pos            <= '0;
    cmd_in.z_pos            <= '0;
    cmd_in.w_pos            <= '0;
    cmd_in.joystick_pressed <= 1'b0;
    cfg_write               <= 1'b0;
    cfg_index               <= cfsr_pkg::REG_REPORT_INTERVAL;
    cfg_data                <= '0;

    foreach (fb_bytes[i]) fb_bytes[i] = '0;
    fb_idx     = 0;
    fb_crc     = '0;
    fb_last_id = '0;
    fb_crc_bad = 1'b0;
    mv_prev    = 1'b0;
    since_us   = '0;
    p_interval = cfsr_pkg::INTERVAL_RESET;
    p_version  = cfsr_pkg::VERSION_RESET;

    // directed rows, reset register values throughout
    // quiet tick after reset: nothing due
    tab.push_back(mk_tick(16'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, 0, 8'h00));
    // max elapsed, extreme positions, moving, button
    tab.push_back(mk_tick(16'hFFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h0, 1'b1, cfsr_pkg::STATUS_BYTES, 1, cfsr_pkg::STAT_MOVING));
    // motion stops: forced report although the counter is at zero
    tab.push_back(mk_tick(16'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0,
                          cfsr_pkg::STATUS_BYTES, 22, cfsr_pkg::VERSION_RESET));
    // good frame, replayed without its CRC
    for (int i = 0; i < FRAME_BYTES - 1; i++)
      tab.push_back(mk_byte(GOOD_BODY[55 - 8 * i -: 8], CLOSE_NONE, 0, 0, 8'h00));
    tab.push_back(mk_byte(8'h00, CLOSE_GOOD, REPLAY_BYTES, 0, 8'hFF));
    // bad frame: silent, but raises the error flag and latches the id
    for (int i = 0; i < FRAME_BYTES - 1; i++)
      tab.push_back(mk_byte(BAD_BODY[55 - 8 * i -: 8], CLOSE_NONE, 0, 0, 8'h00));
    tab.push_back(mk_byte(8'h00, CLOSE_BAD, 0, 0, 8'h00));
    tab.push_back(mk_tick(16'hFFFF, 1'b0, 32'h0123_4567, 32'h89AB_CDEF, 32'h00FF_00FF,
                          32'hFF00_FF00, 1'b0, cfsr_pkg::STATUS_BYTES, 1,
                          cfsr_pkg::STAT_CRC_ERROR));
    // one short of the interval, then exactly on it
    tab.push_back(mk_tick(16'd9999, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, 0, 8'h00));
    tab.push_back(mk_tick(16'd1, 1'b0, 32'h1, 32'h2, 32'h3, 32'h4, 1'b1,
                          cfsr_pkg::STATUS_BYTES, 0, 8'h5A));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tab[i]) begin
      r = tab[i];
      if (r.close == CLOSE_GOOD)
        r.it.rx_byte = fb_crc;
      else if (r.close == CLOSE_BAD)
        r.it.rx_byte = fb_crc ^ 8'h01;
      send_item(r.it, n);
      if (r.n_exp >= 0) begin
        check_field("directed result count", r.n_exp, n);
        if (n == r.n_exp && n > 0)
          check_field("directed byte", 32'(r.chk_byte),
                      32'(pending_bytes[pending_bytes.size() - n + r.chk_at].out_byte));
      end
    end

    // shortest interval, top version; receiver holds off while items keep coming
    set_regs(20'd1, 8'hFF);
    idle_pct = 0;
    hold_reqs++;
    run_phase(20, 3);
    idle_pct = 32;
    run_phase(15, 3);

    // longest interval: reports come mostly from motion stopping
    set_regs(20'd1000000, 8'h00);
    run_phase(30, 65535);

    set_regs((cfsr_pkg::INTERVAL_W)'($urandom_range(1, 70000)),
             (cfsr_pkg::BYTE_W)'($urandom_range(0, 255)));
    run_phase(30, 20000);

    // no idling on either side for a stretch
    set_regs(20'h7FFFF, cfsr_pkg::VERSION_RESET);
    idle_pct = 0;
    run_phase(20, 65535);
    idle_pct = 32;
    run_phase(15, 65535);

    drain_results(TAIL_CYCLES);
    if (errors == 0)
      $display("crc8_command_framer_and_status_reporter_tb OK");
    else
      $display("crc8_command_framer_and_status_reporter_tb NOT OK");
    $finish;
  end

endmodule
